// ----- hdl/tds_pkg.sv -----
// Shared types, sizes and codes for the task dispatch scheduler.
// No dependencies; every other file depends on this package.
`default_nettype none
package tds_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TIME_W    = 16;
    localparam int PRI_W     = 8;
    localparam int STS_W     = 3;
    localparam int OSLOT_W   = 4;
    localparam int POL_W     = 2;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [STS_W-1:0] ST_RAN   = 3'd0;
    localparam logic [STS_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STS_W-1:0] ST_ADDED = 3'd3;
    localparam logic [STS_W-1:0] ST_FULL  = 3'd4;

    localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
    localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
    localparam logic [POL_W-1:0] POL_PRIO = 2'd2;
    localparam logic [POL_W-1:0] POL_RR   = 2'd3;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RR_SCAN, S_RR_CUR, S_RR_PICK,
        S_BEST_SCAN, S_RUN, S_FIN1, S_FIN2, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_ADD, OP_RES_FULL, OP_RES_EMPTY, OP_RES_IDLE,
        OP_SCAN_INIT, OP_RR_STEP, OP_RR_CUR, OP_RR_POP, OP_BEST_STEP,
        OP_SEL_CUR, OP_SEL_BEST, OP_RUN, OP_FIN1, OP_FIN2
    } t_dp_op;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic rr;
        logic cur_used;
        logic scan_done;
        logic rr_empty;
        logic found;
        logic run_left;
    } t_dp_stat;

    typedef struct packed {
        logic [STS_W-1:0]   status;
        logic [OSLOT_W-1:0] task_slot;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  run_length;
        logic               finished;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  wait_time;
    } t_result;

    function automatic logic [OSLOT_W-1:0] out_slot(input logic [SLOT_W-1:0] s);
        logic [OSLOT_W-1:0] r;
        r = '0;
        for (int b = 0; b < OSLOT_W; b++) begin
            if (b < SLOT_W) begin
                r[b] = s[b];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tds_in_if.sv -----
// Input channel of the task dispatch scheduler: valid/ready plus item fields.
// Depends on tds_pkg for field widths.
`default_nettype none
interface tds_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tds_pkg::TIME_W-1:0]  arrival_time;
    logic [tds_pkg::TIME_W-1:0]  burst_time;
    logic [tds_pkg::PRI_W-1:0]   priority_level;

    modport source (output valid, cmd, arrival_time, burst_time, priority_level,
                    input ready);
    modport sink (input valid, cmd, arrival_time, burst_time, priority_level,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/tds_out_if.sv -----
// Result channel of the task dispatch scheduler: valid/ready plus result fields.
// Depends on tds_pkg for field widths.
`default_nettype none
interface tds_out_if;
    logic                         valid;
    logic                         ready;
    logic [tds_pkg::STS_W-1:0]    status;
    logic [tds_pkg::OSLOT_W-1:0]  task_slot;
    logic [tds_pkg::TIME_W-1:0]   start_time;
    logic [tds_pkg::TIME_W-1:0]   run_length;
    logic                         finished;
    logic [tds_pkg::TIME_W-1:0]   turnaround;
    logic [tds_pkg::TIME_W-1:0]   wait_time;

    modport source (output valid, status, task_slot, start_time, run_length, finished,
                    turnaround, wait_time, input ready);
    modport sink (input valid, status, task_slot, start_time, run_length, finished,
                  turnaround, wait_time, output ready);
endinterface
`default_nettype wire

// ----- hdl/task_dispatch_scheduler_top.sv -----
// Top level of the task dispatch scheduler: APB registers, result register,
// controller and datapath. Depends on tds_pkg, tds_in_if, tds_out_if, tds_ctrl, tds_dp.
//
//   Channel   Dir   Handshake          Carries
//   i_task    in    valid/ready        cmd, arrival_time, burst_time, priority_level
//   o_result  out   valid/ready        status, task_slot, start_time, run_length,
//                                      finished, turnaround, wait_time
//   APB       in    psel/penable       policy (0x0), quantum (0x4)
//
// One item at a time. An add goes through the decode state to the result register.
// A dispatch scans the add order one entry a cycle; a finishing task adds the
// finish states FIN1 and FIN2, and round robin adds the RR_CUR and RR_PICK states.
// The length of the table scan sets how long a dispatch takes.
// Synchronous active-low reset empties the table and queues and zeroes time.
// A held result stalls the next result only; the next item is taken meanwhile.
`default_nettype none
module task_dispatch_scheduler_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tds_in_if.sink                           i_task,
    tds_out_if.source                        o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tds_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tds_pkg::DATA_W-1:0]  pwdata,
    output logic      [tds_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import tds_pkg::*;

    logic [POL_W-1:0]  r_policy;
    logic [TIME_W-1:0] r_quantum;
    logic              r_out_valid;
    t_result           r_out;

    t_dp_stat dp_stat;
    t_dp_op   dp_op;
    t_result  dp_res;
    logic     emit;
    logic     out_free;

    // register writes complete on the access phase
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FCFS;
            r_quantum <= TIME_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_POLICY:  r_policy  <= pwdata[POL_W-1:0];
                REG_QUANTUM: r_quantum <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end
    assign prdata = (paddr[2] == REG_QUANTUM) ? DATA_W'(r_quantum) : DATA_W'(r_policy);

    // result register parts the datapath from the output side
    assign out_free = !r_out_valid || o_result.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (emit) r_out <= dp_res;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out.status;
    assign o_result.task_slot  = r_out.task_slot;
    assign o_result.start_time = r_out.start_time;
    assign o_result.run_length = r_out.run_length;
    assign o_result.finished   = r_out.finished;
    assign o_result.turnaround = r_out.turnaround;
    assign o_result.wait_time  = r_out.wait_time;

    tds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_task.valid),
        .o_in_ready (i_task.ready),
        .i_stat     (dp_stat),
        .o_op       (dp_op),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    tds_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (dp_op),
        .i_policy         (r_policy),
        .i_quantum        (r_quantum),
        .i_cmd            (i_task.cmd),
        .i_arrival_time   (i_task.arrival_time),
        .i_burst_time     (i_task.burst_time),
        .i_priority_level (i_task.priority_level),
        .o_stat           (dp_stat),
        .o_res            (dp_res)
    );

    // an accepted item leaves the controller busy for the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_task.valid && i_task.ready) |=> !i_task.ready)
        else $error("input taken twice in a row");

    // a result only loads when the register is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || o_result.ready))
        else $error("result overwritten");

    // only a run result carries the finished flag
    a_finish_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.finished) |-> (o_result.status == ST_RAN))
        else $error("finished flag on non-run result");
endmodule
`default_nettype wire

// ----- hdl/tds_ctrl.sv -----
// Controller state machine of the task dispatch scheduler.
// Depends on tds_pkg; drives datapath operations from datapath status.
`default_nettype none
module tds_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tds_pkg::t_dp_stat i_stat,
    output tds_pkg::t_dp_op        o_op,
    input  wire logic              i_out_free,
    output logic                   o_emit
);
    import tds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_add || i_stat.empty) n_state = S_EMIT;
                else if (i_stat.rr) n_state = S_RR_SCAN;
                else if (i_stat.cur_used) n_state = S_RUN;
                else n_state = S_BEST_SCAN;
            end
            S_RR_SCAN: begin
                if (i_stat.scan_done) n_state = S_RR_CUR;
            end
            S_RR_CUR:  n_state = S_RR_PICK;
            S_RR_PICK: n_state = i_stat.rr_empty ? S_EMIT : S_RUN;
            S_BEST_SCAN: begin
                if (i_stat.scan_done) n_state = i_stat.found ? S_RUN : S_EMIT;
            end
            S_RUN:  n_state = i_stat.run_left ? S_EMIT : S_FIN1;
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = OP_LATCH;
            end
            S_DECODE: begin
                if (i_stat.is_add) o_op = i_stat.full ? OP_RES_FULL : OP_ADD;
                else if (i_stat.empty) o_op = OP_RES_EMPTY;
                else if (!i_stat.rr && i_stat.cur_used) o_op = OP_SEL_CUR;
                else o_op = OP_SCAN_INIT;
            end
            S_RR_SCAN: begin
                if (!i_stat.scan_done) o_op = OP_RR_STEP;
            end
            S_RR_CUR:  o_op = OP_RR_CUR;
            S_RR_PICK: o_op = i_stat.rr_empty ? OP_RES_IDLE : OP_RR_POP;
            S_BEST_SCAN: begin
                if (!i_stat.scan_done) o_op = OP_BEST_STEP;
                else o_op = i_stat.found ? OP_SEL_BEST : OP_RES_IDLE;
            end
            S_RUN:  o_op = OP_RUN;
            S_FIN1: o_op = OP_FIN1;
            S_FIN2: o_op = OP_FIN2;
            S_EMIT: o_emit = i_out_free;
            default: o_op = OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/tds_dp.sv -----
// Datapath of the task dispatch scheduler: task table, add order, ready queue,
// time counter and result fields. Depends on tds_pkg; driven by tds_ctrl.
`default_nettype none
module tds_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tds_pkg::t_dp_op              i_op,
    input  wire logic [tds_pkg::POL_W-1:0]    i_policy,
    input  wire logic [tds_pkg::TIME_W-1:0]   i_quantum,
    input  wire logic                         i_cmd,
    input  wire logic [tds_pkg::TIME_W-1:0]   i_arrival_time,
    input  wire logic [tds_pkg::TIME_W-1:0]   i_burst_time,
    input  wire logic [tds_pkg::PRI_W-1:0]    i_priority_level,
    output tds_pkg::t_dp_stat                 o_stat,
    output tds_pkg::t_result                  o_res
);
    import tds_pkg::*;

    logic [TIME_W-1:0] r_arr  [MAX_TASKS];
    logic [TIME_W-1:0] r_bur  [MAX_TASKS];
    logic [TIME_W-1:0] r_rem  [MAX_TASKS];
    logic [PRI_W-1:0]  r_pri  [MAX_TASKS];
    logic [SLOT_W-1:0] r_aol  [MAX_TASKS];
    logic [SLOT_W-1:0] r_fifo [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_used;
    logic [MAX_TASKS-1:0] r_inq;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rc;
    logic [SLOT_W-1:0] r_cs;
    logic              r_cv;
    logic [TIME_W-1:0] r_time;

    logic              r_cmd;
    logic [TIME_W-1:0] r_in_arr;
    logic [TIME_W-1:0] r_in_bur;
    logic [PRI_W-1:0]  r_in_pri;

    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    logic [SLOT_W-1:0] r_best;
    logic [TIME_W-1:0] r_best_key;
    logic [SLOT_W-1:0] r_sel;
    logic [TIME_W-1:0] r_limit;
    t_result           r_res;

    logic [SLOT_W-1:0] scan_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [TIME_W-1:0] rd_arr;
    logic [TIME_W-1:0] scan_key;
    logic              arrived;
    logic [SLOT_W-1:0] free_slot;
    logic              free_any;
    logic [TIME_W-1:0] q_eff;
    logic [TIME_W-1:0] sel_rem;
    logic [TIME_W-1:0] run_len;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;
    logic [TIME_W:0]   idle_sum;
    logic [TIME_W-1:0] idle_sat;
    logic [SLOT_W-1:0] fifo_tgt;
    logic [MAX_TASKS-1:0] aol_gone;
    logic [MAX_TASKS-1:0] fifo_gone;
    logic [SLOT_W-1:0] aol_next  [MAX_TASKS];
    logic [SLOT_W-1:0] fifo_next [MAX_TASKS];
    logic              rr_take;
    logic              cur_take;

    assign scan_slot = r_aol[r_idx[SLOT_W-1:0]];
    assign rd_slot   = (i_op == OP_RR_STEP || i_op == OP_BEST_STEP) ? scan_slot : r_sel;
    assign rd_arr    = r_arr[rd_slot];
    assign arrived   = (rd_arr <= r_time);

    always_comb begin
        unique case (i_policy)
            POL_FCFS: scan_key = r_arr[scan_slot];
            POL_SJF:  scan_key = r_bur[scan_slot];
            default:  scan_key = {{(TIME_W-PRI_W){1'b0}}, r_pri[scan_slot]};
        endcase
    end

    // lowest free slot
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = SLOT_W'(k);
                free_any  = 1'b1;
            end
        end
    end

    assign q_eff    = (i_quantum == '0) ? TIME_W'(1) : i_quantum;
    assign sel_rem  = r_rem[r_sel];
    assign run_len  = (r_limit < sel_rem) ? r_limit : sel_rem;
    assign time_sum = {1'b0, r_time} + {1'b0, run_len};
    assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
    assign idle_sum = {1'b0, r_time} + (TIME_W+1)'(1);
    assign idle_sat = idle_sum[TIME_W] ? '1 : idle_sum[TIME_W-1:0];

    assign rr_take  = !(r_cv && scan_slot == r_cs) && arrived && !r_inq[scan_slot]
                      && (r_rc < CNT_W'(MAX_TASKS));
    assign cur_take = r_cv && !r_inq[r_cs] && (r_rc < CNT_W'(MAX_TASKS));

    // close the gap left by one removed entry
    assign fifo_tgt = (i_op == OP_RR_POP) ? r_fifo[0] : r_sel;
    always_comb begin
        logic a_acc;
        logic f_acc;
        a_acc = 1'b0;
        f_acc = 1'b0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            a_acc = a_acc | ((CNT_W'(k) < r_cnt) && (r_aol[k] == r_sel));
            f_acc = f_acc | ((CNT_W'(k) < r_rc) && (r_fifo[k] == fifo_tgt));
            aol_gone[k]  = a_acc;
            fifo_gone[k] = f_acc;
            aol_next[k]  = r_aol[k];
            fifo_next[k] = r_fifo[k];
            if (k < MAX_TASKS - 1) begin
                if (a_acc) aol_next[k]  = r_aol[k+1];
                if (f_acc) fifo_next[k] = r_fifo[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_inq   <= '0;
            r_cnt   <= '0;
            r_rc    <= '0;
            r_cs    <= '0;
            r_cv    <= 1'b0;
            r_time  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (i_op)
                OP_ADD: begin
                    r_used[free_slot] <= 1'b1;
                    r_cnt             <= r_cnt + CNT_W'(1);
                end
                OP_RES_IDLE: r_time <= idle_sat;
                OP_SCAN_INIT: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                OP_RR_STEP: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (rr_take) begin
                        r_inq[scan_slot] <= 1'b1;
                        r_rc             <= r_rc + CNT_W'(1);
                    end
                end
                OP_RR_CUR: begin
                    r_cv <= 1'b0;
                    if (cur_take) begin
                        r_inq[r_cs] <= 1'b1;
                        r_rc        <= r_rc + CNT_W'(1);
                    end
                end
                OP_RR_POP: begin
                    r_inq[r_fifo[0]] <= 1'b0;
                    r_rc             <= r_rc - CNT_W'(1);
                end
                OP_BEST_STEP: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (arrived && (!r_found || scan_key < r_best_key)) begin
                        r_found <= 1'b1;
                    end
                end
                OP_RUN: begin
                    r_time <= time_sat;
                    if (sel_rem > r_limit) begin
                        r_cv <= 1'b1;
                        r_cs <= r_sel;
                    end
                end
                OP_FIN2: begin
                    r_used[r_sel] <= 1'b0;
                    r_inq[r_sel]  <= 1'b0;
                    r_cnt         <= r_cnt - CNT_W'(1);
                    if (r_inq[r_sel]) r_rc <= r_rc - CNT_W'(1);
                    r_cv <= 1'b0;
                    r_cs <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload: table, lists and result fields
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_cmd    <= i_cmd;
                r_in_arr <= i_arrival_time;
                r_in_bur <= i_burst_time;
                r_in_pri <= i_priority_level;
            end
            OP_ADD: begin
                r_arr[free_slot]        <= r_in_arr;
                r_bur[free_slot]        <= r_in_bur;
                r_rem[free_slot]        <= r_in_bur;
                r_pri[free_slot]        <= r_in_pri;
                r_aol[r_cnt[SLOT_W-1:0]] <= free_slot;
                r_res <= '{status: ST_ADDED, task_slot: out_slot(free_slot), default: '0};
            end
            OP_RES_FULL:  r_res <= '{status: ST_FULL, default: '0};
            OP_RES_EMPTY: r_res <= '{status: ST_EMPTY, default: '0};
            OP_RES_IDLE: begin
                r_res <= '{status: ST_IDLE, start_time: r_time,
                           run_length: TIME_W'(1), default: '0};
            end
            OP_RR_STEP: begin
                if (rr_take) r_fifo[r_rc[SLOT_W-1:0]] <= scan_slot;
            end
            OP_RR_CUR: begin
                if (cur_take) r_fifo[r_rc[SLOT_W-1:0]] <= r_cs;
            end
            OP_RR_POP: begin
                r_sel   <= r_fifo[0];
                r_limit <= q_eff;
                for (int k = 0; k < MAX_TASKS; k++) begin
                    if (fifo_gone[k]) r_fifo[k] <= fifo_next[k];
                end
            end
            OP_BEST_STEP: begin
                if (arrived && (!r_found || scan_key < r_best_key)) begin
                    r_best     <= scan_slot;
                    r_best_key <= scan_key;
                end
            end
            OP_SEL_CUR: begin
                r_sel   <= r_cs;
                r_limit <= TIME_W'(1);
            end
            OP_SEL_BEST: begin
                r_sel   <= r_best;
                r_limit <= TIME_W'(1);
            end
            OP_RUN: begin
                r_rem[r_sel] <= sel_rem - run_len;
                r_res <= '{status: ST_RAN, task_slot: out_slot(r_sel), start_time: r_time,
                           run_length: run_len, default: '0};
            end
            OP_FIN1: begin
                r_res.turnaround <= (r_time >= rd_arr) ? r_time - rd_arr : '0;
            end
            OP_FIN2: begin
                r_res.finished  <= 1'b1;
                r_res.wait_time <= (r_res.turnaround > r_bur[r_sel])
                                   ? r_res.turnaround - r_bur[r_sel] : '0;
                for (int k = 0; k < MAX_TASKS; k++) begin
                    if (aol_gone[k]) r_aol[k] <= aol_next[k];
                    if (fifo_gone[k]) r_fifo[k] <= fifo_next[k];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.is_add    = (r_cmd == CMD_ADD);
        o_stat.full      = (r_cnt >= CNT_W'(MAX_TASKS)) || !free_any;
        o_stat.empty     = (r_cnt == '0);
        o_stat.rr        = (i_policy == POL_RR);
        o_stat.cur_used  = r_cv && r_used[r_cs];
        o_stat.scan_done = (r_idx >= r_cnt);
        o_stat.rr_empty  = (r_rc == '0);
        o_stat.found     = r_found;
        o_stat.run_left  = (sel_rem > r_limit);
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ----- dv/task_dispatch_scheduler_top_test.sv -----
// Self-checking testbench for the task dispatch scheduler: directed table plus random traffic,
// every result compared against a behavioral scheduler model kept in this file.
// Depends on tds_pkg, tds_in_if, tds_out_if and task_dispatch_scheduler_top.
`default_nettype none
module task_dispatch_scheduler_top_test;
    import tds_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * (MAX_TASKS + 8);

    typedef struct {
        logic        cmd;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        bit          has_exp;  // typed-in expectation present
        t_result     exp;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    tds_in_if  task_ch ();
    tds_out_if res_ch ();

    task_dispatch_scheduler_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_task(task_ch.sink), .o_result(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Scheduler model state, mirrored from the block's behavior.
    logic [15:0] m_arrival [MAX_TASKS];
    logic [15:0] m_burst   [MAX_TASKS];
    logic [15:0] m_remain  [MAX_TASKS];
    logic [7:0]  m_prio    [MAX_TASKS];
    bit          m_used    [MAX_TASKS];
    int          task_order[$];
    int          ready_q[$];
    int          cur_slot;
    bit          cur_valid;
    int          now;
    logic [1:0]  m_policy;
    logic [15:0] m_quantum;

    t_result sched_expected[$];
    int      error_count;
    int      idle_results, ran_results, finish_results, full_results, empty_results;
    int      accepted_items;
    bit      draining;
    bit      in_stall_on;   // random idling enabled

    function automatic t_result make_res(logic [2:0] st, int slot, int start, int len,
                                         bit fin, int ta, int wt);
        t_result r;
        r.status = st;
        r.task_slot = slot[3:0];
        r.start_time = start[15:0];
        r.run_length = len[15:0];
        r.finished = fin;
        r.turnaround = ta[15:0];
        r.wait_time = wt[15:0];
        return r;
    endfunction

    function automatic void drop_slot(ref int q[$], input int s);
        foreach (q[i]) begin
            if (q[i] == s) begin
                q.delete(i);
                return;
            end
        end
    endfunction

    function automatic bit has_slot(ref int q[$], input int s);
        foreach (q[i]) begin
            if (q[i] == s) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Run slot s for up to lim units and build the result.
    function automatic t_result run_slot(int s, int lim);
        int rl, start, ta, wt;
        rl = (lim < m_remain[s]) ? lim : m_remain[s];
        start = now;
        m_remain[s] = m_remain[s] - rl;
        now = (now + rl > 65535) ? 65535 : now + rl;
        if (m_remain[s] != 0) begin
            cur_valid = 1'b1;
            cur_slot = s;
            return make_res(ST_RAN, s, start, rl, 1'b0, 0, 0);
        end
        ta = (now >= m_arrival[s]) ? now - m_arrival[s] : 0;
        wt = (ta > m_burst[s]) ? ta - m_burst[s] : 0;
        m_used[s] = 1'b0;
        drop_slot(task_order, s);
        drop_slot(ready_q, s);
        cur_valid = 1'b0;
        cur_slot = 0;
        return make_res(ST_RAN, s, start, rl, 1'b1, ta, wt);
    endfunction

    function automatic t_result idle_step();
        int start;
        start = now;
        now = (now + 1 > 65535) ? 65535 : now + 1;
        return make_res(ST_IDLE, 0, start, 1, 1'b0, 0, 0);
    endfunction

    function automatic int policy_key(int s);
        if (m_policy == POL_FCFS) return m_arrival[s];
        if (m_policy == POL_SJF) return m_burst[s];
        return m_prio[s];
    endfunction

    function automatic t_result schedule_step(logic cmd, logic [15:0] arr, logic [15:0] bur,
                                              logic [7:0] pri);
        int s, best, q;
        bit found;
        if (cmd == CMD_ADD) begin
            if (task_order.size() >= MAX_TASKS) return make_res(ST_FULL, 0, 0, 0, 0, 0, 0);
            for (s = 0; s < MAX_TASKS; s++) begin
                if (!m_used[s]) break;
            end
            m_used[s] = 1'b1;
            m_arrival[s] = arr;
            m_burst[s] = bur;
            m_remain[s] = bur;
            m_prio[s] = pri;
            task_order.insert(task_order.size(), s);
            return make_res(ST_ADDED, s, 0, 0, 0, 0, 0);
        end
        if (task_order.size() == 0) return make_res(ST_EMPTY, 0, 0, 0, 0, 0, 0);
        if (m_policy == POL_RR) begin
            q = (m_quantum == 0) ? 1 : m_quantum;
            foreach (task_order[i]) begin
                s = task_order[i];
                if (cur_valid && s == cur_slot) continue;
                if (m_arrival[s] > now) continue;
                if (has_slot(ready_q, s)) continue;
                ready_q.insert(ready_q.size(), s);
            end
            if (cur_valid) begin
                if (!has_slot(ready_q, cur_slot)) ready_q.insert(ready_q.size(), cur_slot);
                cur_valid = 1'b0;
            end
            if (ready_q.size() == 0) return idle_step();
            s = ready_q.pop_front();
            return run_slot(s, q);
        end
        if (cur_valid && m_used[cur_slot]) return run_slot(cur_slot, 1);
        found = 1'b0;
        best = 0;
        foreach (task_order[i]) begin
            s = task_order[i];
            if (m_arrival[s] > now) continue;
            if (found && policy_key(s) >= policy_key(best)) continue;
            best = s;
            found = 1'b1;
        end
        if (!found) return idle_step();
        return run_slot(best, 1);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // Result monitor: compare every transfer on the result channel.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (sched_expected.size() == 0) begin
                report_mismatch("unexpected result, status", res_ch.status, -1);
            end else begin
                want = sched_expected.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
                if (res_ch.task_slot !== want.task_slot)
                    report_mismatch("task_slot", res_ch.task_slot, want.task_slot);
                if (res_ch.start_time !== want.start_time)
                    report_mismatch("start_time", res_ch.start_time, want.start_time);
                if (res_ch.run_length !== want.run_length)
                    report_mismatch("run_length", res_ch.run_length, want.run_length);
                if (res_ch.finished !== want.finished)
                    report_mismatch("finished", res_ch.finished, want.finished);
                if (res_ch.turnaround !== want.turnaround)
                    report_mismatch("turnaround", res_ch.turnaround, want.turnaround);
                if (res_ch.wait_time !== want.wait_time)
                    report_mismatch("wait_time", res_ch.wait_time, want.wait_time);
                case (want.status)
                    ST_IDLE:  idle_results++;
                    ST_FULL:  full_results++;
                    ST_EMPTY: empty_results++;
                    ST_RAN: begin
                        ran_results++;
                        if (want.finished) finish_results++;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Receiver: drop ready at random while idling is enabled.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (in_stall_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 10);
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
        end
    end

    // Watchdog: count cycles without any transfer.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((task_ch.valid && task_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("task_dispatch_scheduler_top_test NOT OK");
                $finish;
            end
        end
    end

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic apb_write(input logic regsel, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_W'({regsel, 2'b00});
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (regsel == REG_POLICY) m_policy = value[1:0];
        else m_quantum = value[15:0];
    endtask

    // Wait until every expectation has come back, then let the block settle.
    task automatic wait_settled();
        while (sched_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [1:0] pol, input logic [15:0] qt);
        wait_settled();
        apb_write(REG_POLICY, DATA_W'(pol));
        apb_write(REG_QUANTUM, DATA_W'(qt));
    endtask

    // Present one item, optionally after a random gap; predict at transfer.
    task automatic send_item(input logic cmd, input logic [15:0] arr, input logic [15:0] bur,
                             input logic [7:0] pri, input bit typed, input t_result typed_res);
        t_result pred;
        if (in_stall_on && $urandom_range(0, 5) == 0) begin
            task_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        task_ch.valid = 1'b1;
        task_ch.cmd = cmd;
        task_ch.arrival_time = arr;
        task_ch.burst_time = bur;
        task_ch.priority_level = pri;
        do @(posedge i_clk); while (!task_ch.ready);
        pred = schedule_step(cmd, arr, bur, pri);
        if (typed && pred != typed_res)
            report_mismatch("directed row disagrees with model, status", pred.status,
                            typed_res.status);
        sched_expected.insert(sched_expected.size(), typed ? typed_res : pred);
        accepted_items++;
        @(negedge i_clk);
        task_ch.valid = 1'b0;
    endtask

    task automatic random_add(input bit short_burst);
        logic [15:0] arr, bur;
        arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(now + $urandom_range(0, 8));
        bur = short_burst ? 16'($urandom_range(0, 6)) : 16'($urandom);
        send_item(CMD_ADD, arr, bur, 8'($urandom), 1'b0, '0);
    endtask

    // Directed table: extremes, empty, full, zero burst and idle.
    t_stim_row directed [$];

    function automatic t_stim_row row(logic cmd, int arr, int bur, int pri, bit typed,
                                      t_result r);
        t_stim_row x;
        x.cmd = cmd;
        x.arrival = arr[15:0];
        x.burst = bur[15:0];
        x.prio = pri[7:0];
        x.has_exp = typed;
        x.exp = r;
        return x;
    endfunction

    initial begin
        logic [1:0] pol;
        int n_dispatch;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        task_ch.valid = 1'b0;
        task_ch.cmd = CMD_ADD;
        task_ch.arrival_time = '0;
        task_ch.burst_time = '0;
        task_ch.priority_level = '0;
        in_stall_on = 1'b1;
        error_count = 0;
        accepted_items = 0;
        m_used = '{default: 1'b0};
        cur_valid = 1'b0;
        cur_slot = 0;
        now = 0;
        m_policy = POL_FCFS;
        m_quantum = 16'd1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset: empty dispatch, then adds at extremes.
        directed.insert(directed.size(), row(CMD_DISPATCH, 16'hFFFF, 16'hFFFF, 255, 1,
                        make_res(ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        directed.insert(directed.size(), row(CMD_ADD, 0, 0, 0, 1,
                        make_res(ST_ADDED, 0, 0, 0, 0, 0, 0)));
        directed.insert(directed.size(), row(CMD_DISPATCH, 0, 0, 0, 1,
                        make_res(ST_RAN, 0, 0, 0, 1, 0, 0)));
        directed.insert(directed.size(), row(CMD_ADD, 5, 2, 255, 1,
                        make_res(ST_ADDED, 0, 0, 0, 0, 0, 0)));
        directed.insert(directed.size(), row(CMD_DISPATCH, 0, 0, 0, 1,
                        make_res(ST_IDLE, 0, 0, 1, 0, 0, 0)));
        for (int i = 1; i < MAX_TASKS; i++)
            directed.insert(directed.size(), row(CMD_ADD, i, 16'hFFFF - i, i * 17, 1,
                            make_res(ST_ADDED, i, 0, 0, 0, 0, 0)));
        directed.insert(directed.size(), row(CMD_ADD, 1, 1, 0, 1,
                        make_res(ST_FULL, 0, 0, 0, 0, 0, 0)));
        for (int i = 0; i < 4; i++)
            directed.insert(directed.size(), row(CMD_DISPATCH, 0, 0, 0, 0, '0));
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].arrival, directed[i].burst,
                      directed[i].prio, directed[i].has_exp, directed[i].exp);

        // Policy sweep with a few dispatches each; the extremes of quantum included.
        reconfigure(POL_SJF, 16'd1);
        repeat (4) send_item(CMD_DISPATCH, 0, 0, 0, 1'b0, '0);
        reconfigure(POL_PRIO, 16'd0);
        repeat (4) send_item(CMD_DISPATCH, 0, 0, 0, 1'b0, '0);
        reconfigure(POL_RR, 16'hFFFF);
        repeat (20) send_item(CMD_DISPATCH, 0, 0, 0, 1'b0, '0);

        // Random phases: reset-free, so time climbs toward saturation and stays there.
        for (int phase = 0; phase < 14; phase++) begin
            pol = 2'($urandom_range(0, 3));
            reconfigure(pol, (phase % 4 == 0) ? 16'd1 :
                             (phase % 4 == 1) ? 16'hFFFF : 16'($urandom_range(0, 5)));
            if (phase == 12) in_stall_on = 1'b0;
            // about 46 items per phase
            while (accepted_items < 53 + (phase + 1) * 46) begin
                if ($urandom_range(0, 2) == 0 || task_order.size() == MAX_TASKS) begin
                    n_dispatch = $urandom_range(1, 4);
                    repeat (n_dispatch) send_item(CMD_DISPATCH, 16'($urandom), 16'($urandom),
                                                  8'($urandom), 1'b0, '0);
                end else begin
                    random_add($urandom_range(0, 3) != 0);
                end
            end
            // Sender holds off until the block has answered everything.
            if (phase == 6) wait_settled();
        end

        wait_settled();
        $display("covered %0d items: %0d runs (%0d finished), %0d idle, %0d full, %0d empty",
                 accepted_items, ran_results, finish_results, idle_results, full_results,
                 empty_results);
        $display("all four policies visited, quantum 0, 1 and 65535 applied");
        if (error_count == 0) begin
            $display("task_dispatch_scheduler_top_test OK");
        end else begin
            $display("task_dispatch_scheduler_top_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
